// ----- design/modbus_rtu_request_framer_defines.svh -----
// Assertion macros for the Modbus RTU request framer.
`ifndef MODBUS_RTU_REQUEST_FRAMER_DEFINES_SVH
`define MODBUS_RTU_REQUEST_FRAMER_DEFINES_SVH
`ifndef SYNTHESIS
`define MRF_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define MRF_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define MRF_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define MRF_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

// ----- design/mrf_pkg.sv -----
// Shared types, codes and CRC function for the Modbus RTU request framer.
package mrf_pkg;

    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [2:0] OP_FC01 = 3'd0;
    localparam logic [2:0] OP_FC02 = 3'd1;
    localparam logic [2:0] OP_FC03 = 3'd2;
    localparam logic [2:0] OP_FC04 = 3'd3;
    localparam logic [2:0] OP_FC05 = 3'd4;
    localparam logic [2:0] OP_FC06 = 3'd5;
    localparam logic [2:0] OP_FC16 = 3'd6;

    localparam logic KIND_HEADER  = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // One queued command: a whole request header or one payload byte.
    typedef struct packed {
        logic        is_header;
        logic [2:0]  opcode;
        logic [7:0]  slave_addr;
        logic [15:0] reg_addr;
        logic [15:0] count_or_value;
        logic [7:0]  payload_byte;
        logic        last;
    } cmd_t;

    function automatic logic [7:0] fcode_of(input logic [2:0] op);
        logic [7:0] fc;
        case (op)
            OP_FC01: fc = 8'h01;
            OP_FC02: fc = 8'h02;
            OP_FC03: fc = 8'h03;
            OP_FC04: fc = 8'h04;
            OP_FC05: fc = 8'h05;
            OP_FC06: fc = 8'h06;
            OP_FC16: fc = 8'h10;
            default: fc = 8'h00;
        endcase
        return fc;
    endfunction

    function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ----- design/modbus_rtu_request_framer.sv -----
// Header transactions enter the command queue; the back end registers each frame byte
// onto m_tdata. A fixed request gives 8 bytes, a write-multiple header 7 (9 when its
// count is zero); a payload byte gives 1, the last one 3 (data + CRC). One byte per
// cycle goes out while commands are queued and m_tready is high; s_tready drops only
// while the command queue is full, until the back end finishes its head command.
// Reset: synchronous, active low; clears the queue, payload tracking and the CRC.
`include "modbus_rtu_request_framer_defines.svh"
module modbus_rtu_request_framer import mrf_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // opcode[2:0], slave_addr[10:3], reg_addr[26:11], count_or_value[42:27],
    // payload_byte[50:43], zero fill [55:51]
    input  logic [55:0] s_tdata,
    // item_kind[0]
    input  logic [0:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // frame_byte[7:0]
    output logic [7:0]  m_tdata,
    output logic        m_tlast
);

    logic push, pop, q_empty, q_full, fire;
    cmd_t push_cmd, head;

    mrf_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    mrf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .empty    (q_empty),
        .full     (q_full)
    );

    mrf_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .q_empty  (q_empty),
        .pop      (pop),
        .fire     (fire),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    `MRF_ASSERT_IMPL(a_no_push_full, aclk, aresetn, push, !q_full)
    `MRF_ASSERT_IMPL(a_no_pop_empty, aclk, aresetn, pop, !q_empty)
    `MRF_ASSERT_NEXT(a_fire_shows, aclk, aresetn, fire, m_tvalid)

endmodule

// ----- design/mrf_front.sv -----
// Front end: accepts input items, drops invalid ones and queues commands.
module mrf_front import mrf_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,
    input  logic [0:0]  s_tuser,
    input  logic        q_full,
    output logic        push,
    output cmd_t        push_cmd
);

    logic        in_payload_reg, in_payload_next;
    logic [16:0] remaining_reg, remaining_next;
    logic        accept;
    logic [2:0]  opcode;
    logic [15:0] cv;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign opcode   = s_tdata[2:0];
    assign cv       = s_tdata[42:27];

    always_comb begin
        in_payload_next = in_payload_reg;
        remaining_next  = remaining_reg;
        push            = 1'b0;
        push_cmd.is_header      = (s_tuser[0] == KIND_HEADER);
        push_cmd.opcode         = opcode;
        push_cmd.slave_addr     = s_tdata[10:3];
        push_cmd.reg_addr       = s_tdata[26:11];
        push_cmd.count_or_value = cv;
        push_cmd.payload_byte   = s_tdata[50:43];
        push_cmd.last           = (remaining_reg == 17'd1);
        if (accept) begin
            if (s_tuser[0] == KIND_HEADER) begin
                if (opcode <= OP_FC16) begin
                    push = 1'b1;
                    if (opcode == OP_FC16 && cv != 16'd0) begin
                        in_payload_next = 1'b1;
                        remaining_next  = {cv, 1'b0};
                    end else begin
                        in_payload_next = 1'b0;
                        remaining_next  = '0;
                    end
                end
            end else if (in_payload_reg && remaining_reg != 17'd0) begin
                push           = 1'b1;
                remaining_next = remaining_reg - 17'd1;
                if (remaining_reg == 17'd1) begin
                    in_payload_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_payload_reg <= 1'b0;
            remaining_reg  <= '0;
        end else begin
            in_payload_reg <= in_payload_next;
            remaining_reg  <= remaining_next;
        end
    end

endmodule

// ----- design/mrf_queue.sv -----
// Short command queue between the front end and the byte sequencer.
module mrf_queue import mrf_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head,
    output logic empty,
    output logic full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    cmd_t          mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign head  = mem[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign full  = (count_reg == FULL_CNT);

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CW'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

// ----- design/mrf_back.sv -----
// Back end: walks each queued command byte by byte, runs the CRC, drives the output.
module mrf_back import mrf_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  cmd_t        head,
    input  logic        q_empty,
    output logic        pop,
    output logic        fire,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,
    output logic        m_tlast
);

    typedef enum logic [1:0] {
        BK_DATA,
        BK_CRC_LO,
        BK_CRC_HI
    } byte_kind_t;

    logic [3:0]  idx_reg, idx_next;
    logic [15:0] crc_reg, crc_next;
    logic        m_valid_reg;
    logic [7:0]  m_data_reg;
    logic        m_last_reg;

    byte_kind_t  bkind;
    logic [7:0]  data_byte;
    logic [7:0]  out_byte;
    logic        cmd_done;
    logic        is_fc16;
    logic [15:0] crc_base;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    assign fire    = !q_empty && (!m_valid_reg || m_tready);
    assign pop     = fire && cmd_done;
    assign is_fc16 = (head.opcode == OP_FC16);

    always_comb begin
        bkind     = BK_DATA;
        data_byte = head.payload_byte;
        cmd_done  = 1'b0;
        if (head.is_header) begin
            case (idx_reg)
                4'd0: data_byte = head.slave_addr;
                4'd1: data_byte = fcode_of(head.opcode);
                4'd2: data_byte = head.reg_addr[15:8];
                4'd3: data_byte = head.reg_addr[7:0];
                4'd4: data_byte = head.count_or_value[15:8];
                4'd5: data_byte = head.count_or_value[7:0];
                4'd6: begin
                    // byte count is the low byte of twice the register count
                    data_byte = {head.count_or_value[6:0], 1'b0};
                    if (is_fc16) begin
                        cmd_done = (head.count_or_value != 16'd0);
                    end else begin
                        bkind = BK_CRC_LO;
                    end
                end
                4'd7: begin
                    if (is_fc16) begin
                        bkind = BK_CRC_LO;
                    end else begin
                        bkind    = BK_CRC_HI;
                        cmd_done = 1'b1;
                    end
                end
                default: begin
                    bkind    = BK_CRC_HI;
                    cmd_done = 1'b1;
                end
            endcase
        end else begin
            case (idx_reg)
                4'd0: cmd_done = !head.last;
                4'd1: bkind = BK_CRC_LO;
                default: begin
                    bkind    = BK_CRC_HI;
                    cmd_done = 1'b1;
                end
            endcase
        end
    end

    always_comb begin
        // a header restarts the CRC on its first byte
        crc_base = (head.is_header && idx_reg == 4'd0) ? CRC_INIT : crc_reg;
        crc_next = crc_reg;
        out_byte = data_byte;
        case (bkind)
            BK_DATA:   crc_next = crc_feed(crc_base, data_byte);
            BK_CRC_LO: out_byte = crc_reg[7:0];
            BK_CRC_HI: begin
                out_byte = crc_reg[15:8];
                crc_next = CRC_INIT;
            end
            default:   crc_next = crc_reg;
        endcase
        idx_next = cmd_done ? 4'd0 : idx_reg + 4'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            crc_reg     <= CRC_INIT;
            m_valid_reg <= 1'b0;
            m_last_reg  <= 1'b0;
        end else if (fire) begin
            idx_reg     <= idx_next;
            crc_reg     <= crc_next;
            m_valid_reg <= 1'b1;
            m_last_reg  <= (bkind == BK_CRC_HI);
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_data_reg <= out_byte;
        end
    end

endmodule

// ----- tb/sv/mrf_frame_checker.sv -----
// Watches both streams of the framer, predicts each frame byte and compares it.
`timescale 1ns / 1ps
module mrf_frame_checker import mrf_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    // opcode[2:0], slave_addr[10:3], reg_addr[26:11], count_or_value[42:27],
    // payload_byte[50:43], zero fill [55:51]
    input  logic [55:0] s_tdata,
    // item_kind[0]
    input  logic [0:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    // frame_byte[7:0]
    input  logic [7:0]  m_tdata,
    input  logic        m_tlast,
    output int          fault_count,
    output int          bytes_due
);

    typedef struct packed {
        logic [7:0] octet;
        logic       closes;
    } line_byte_t;

    // Function code on the wire, indexed by opcode.
    localparam logic [7:0] FUNC_CODE [7] = '{8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h10};

    line_byte_t  line_q[$];
    line_byte_t  want;
    logic [15:0] crc_acc;
    logic [16:0] bytes_left;
    logic        awaiting_data;

    // Shift one data bit at a time through the reflected CRC register.
    function automatic logic [15:0] crc_next(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] r;
        logic        fb;
        r = crc;
        for (int i = 0; i < 8; i++) begin
            fb = r[0] ^ b[i];
            r = r >> 1;
            if (fb) begin
                r = r ^ CRC_POLY;
            end
        end
        return r;
    endfunction

    task automatic emit_data(input logic [7:0] b);
        crc_acc = crc_next(crc_acc, b);
        line_q.push_back(line_byte_t'{b, 1'b0});
    endtask

    task automatic emit_crc();
        line_q.push_back(line_byte_t'{crc_acc[7:0], 1'b0});
        line_q.push_back(line_byte_t'{crc_acc[15:8], 1'b1});
        crc_acc = CRC_INIT;
        awaiting_data = 1'b0;
        bytes_left = '0;
    endtask

    task automatic predict_frame_bytes(input logic kind, input logic [55:0] d);
        logic [2:0]  op;
        logic [7:0]  slave;
        logic [15:0] addr;
        logic [15:0] quantity;
        logic [7:0]  data;
        logic [16:0] byte_cnt;
        {data, quantity, addr, slave, op} = d[50:0];
        if (kind == KIND_PAYLOAD) begin
            // drop data bytes that no write-multiple frame is waiting for
            if (!awaiting_data || bytes_left == 0) begin
                return;
            end
            emit_data(data);
            bytes_left = bytes_left - 17'd1;
            if (bytes_left == 0) begin
                emit_crc();
            end
            return;
        end
        if (op > OP_FC16) begin
            return;
        end
        // a new header abandons any unfinished frame
        crc_acc = CRC_INIT;
        awaiting_data = 1'b0;
        bytes_left = '0;
        emit_data(slave);
        emit_data(FUNC_CODE[op]);
        emit_data(addr[15:8]);
        emit_data(addr[7:0]);
        emit_data(quantity[15:8]);
        emit_data(quantity[7:0]);
        if (op == OP_FC16) begin
            byte_cnt = {quantity, 1'b0};
            emit_data(byte_cnt[7:0]);
            if (byte_cnt == 0) begin
                emit_crc();
            end else begin
                bytes_left = byte_cnt;
                awaiting_data = 1'b1;
            end
        end else begin
            emit_crc();
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            line_q.delete();
            crc_acc = CRC_INIT;
            bytes_left = '0;
            awaiting_data = 1'b0;
            fault_count = 0;
        end else begin
            // compare outputs before queuing this edge's input transaction
            if (m_tvalid && m_tready) begin
                if (line_q.size() == 0) begin
                    $error("frame_byte: expected nothing, got 0x%02h", m_tdata);
                    fault_count++;
                end else begin
                    want = line_q.pop_front();
                    if (m_tdata !== want.octet) begin
                        $error("frame_byte: expected 0x%02h, got 0x%02h", want.octet, m_tdata);
                        fault_count++;
                    end
                    if (m_tlast !== want.closes) begin
                        $error("frame_end: expected %0b, got %0b", want.closes, m_tlast);
                        fault_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                predict_frame_bytes(s_tuser[0], s_tdata);
            end
        end
        bytes_due = line_q.size();
    end

endmodule

// ----- tb/sv/modbus_rtu_request_framer_tb.sv -----
// Stimulus and verdict for the Modbus RTU request framer.
`timescale 1ns / 1ps
module modbus_rtu_request_framer_tb import mrf_pkg::*;;

    localparam int         CYCLE_LIMIT  = 200000;
    localparam int         IDLE_PCT     = 37;
    localparam int         RANDOM_ITEMS = 85;
    localparam int         BIG_COUNT    = 20;
    localparam logic [2:0] OP_UNUSED    = 3'd7;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata  = '0;
    logic [0:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        calm     = 1'b0;
    int          fault_count;
    int          bytes_due;
    int          cycle_count = 0;

    modbus_rtu_request_framer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    mrf_frame_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .fault_count (fault_count),
        .bytes_due   (bytes_due)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    always @(negedge aclk) begin
        m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("modbus_rtu_request_framer_tb: done, errors");
            $finish;
        end
    end

    // Enter and leave on a falling edge; return once the transaction is taken.
    task automatic send_item(input logic kind, input logic [2:0] op, input logic [7:0] slave,
                             input logic [15:0] addr, input logic [15:0] quantity,
                             input logic [7:0] data);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 56'({$urandom, $urandom});
            s_tuser  <= 1'($urandom);
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {5'b0, data, quantity, addr, slave, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic send_header(input logic [2:0] op, input logic [7:0] slave,
                               input logic [15:0] addr, input logic [15:0] quantity);
        send_item(KIND_HEADER, op, slave, addr, quantity, 8'($urandom));
    endtask

    task automatic send_data_byte(input logic [7:0] data);
        send_item(KIND_PAYLOAD, 3'($urandom), 8'($urandom), 16'($urandom), 16'($urandom), data);
    endtask

    task automatic send_block(input int n);
        for (int i = 0; i < n; i++) begin
            send_data_byte(8'($urandom));
        end
    endtask

    initial begin
        int counted;
        int r;
        int n;
        int quantity;
        bit big_done;
        counted  = 0;
        big_done = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: field extremes, every function code, corner cases
        send_header(OP_FC01, 8'h00, 16'h0000, 16'h0000);
        send_header(OP_FC02, 8'hFF, 16'hFFFF, 16'hFFFF);
        send_header(OP_FC03, 8'($urandom), 16'($urandom), 16'($urandom));
        send_header(OP_FC04, 8'($urandom), 16'($urandom), 16'($urandom));
        send_header(OP_FC05, 8'h11, 16'h00AC, 16'h1234);
        send_header(OP_FC06, 8'($urandom), 16'($urandom), 16'($urandom));
        send_header(OP_UNUSED, 8'h22, 16'h3344, 16'h5566);
        send_data_byte(8'hFF);
        send_header(OP_FC16, 8'h01, 16'h0010, 16'h0000);
        send_header(OP_FC16, 8'hFF, 16'hFFFF, 16'h0002);
        send_data_byte(8'h00);
        send_data_byte(8'hFF);
        send_data_byte(8'hA5);
        send_data_byte(8'h5A);
        send_data_byte(8'h3C);
        send_header(OP_FC16, 8'h07, 16'h0100, 16'h0003);
        send_data_byte(8'h12);
        send_header(OP_UNUSED, 8'h08, 16'h0200, 16'h0004);
        send_data_byte(8'h34);
        send_header(OP_FC03, 8'h09, 16'h0300, 16'h0005);
        send_header(OP_FC16, 8'h0A, 16'h0400, 16'h8000);
        send_data_byte(8'h56);
        send_header(OP_FC06, 8'h0B, 16'h0500, 16'h0006);

        while (counted < RANDOM_ITEMS) begin
            r = $urandom_range(99);
            if (!big_done && counted >= RANDOM_ITEMS / 2) begin
                // hold both sides busy through a whole write-multiple frame
                calm <= 1'b1;
                send_header(OP_FC16, 8'($urandom), 16'($urandom), 16'(BIG_COUNT));
                send_block(2 * BIG_COUNT);
                calm <= 1'b0;
                big_done = 1'b1;
                counted += 1 + 2 * BIG_COUNT;
            end else if (r < 50) begin
                send_header(3'($urandom_range(OP_FC06)), 8'($urandom), 16'($urandom),
                            16'($urandom));
                counted++;
            end else if (r < 80) begin
                quantity = $urandom_range(4);
                if ($urandom_range(9) == 0) begin
                    quantity = $urandom_range(65535);
                end
                send_header(OP_FC16, 8'($urandom), 16'($urandom), 16'(quantity));
                n = 2 * quantity;
                // cut the frame short now and then; the next header abandons it
                if (quantity > 4 || $urandom_range(9) == 0) begin
                    n = $urandom_range(n < 3 ? n : 3);
                end
                send_block(n);
                counted += 1 + n;
            end else if (r < 92) begin
                send_data_byte(8'($urandom));
                counted++;
            end else begin
                send_header(OP_UNUSED, 8'($urandom), 16'($urandom), 16'($urandom));
                counted++;
            end
        end

        s_tvalid <= 1'b0;
        while (bytes_due != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
        if (fault_count == 0) begin
            $display("modbus_rtu_request_framer_tb: done, clean");
        end else begin
            $display("modbus_rtu_request_framer_tb: done, errors");
        end
        $finish;
    end

endmodule
